FILE: rtl/core/quadratic_bezier_point_generator_unit_macros.svh
// Assertion macros for the quadratic Bezier point generator checker.
// No dependencies; included by qbez_checker.sv.
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH

// Check sampled on clk, masked while rst is high.
`define QBEZ_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check sampled on clk, also live during reset.
`define QBEZ_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/qbez_pkg.sv
// Shared constants and types for the quadratic Bezier point generator.
// No dependencies.
package qbez_pkg;

  localparam int FRACTION_BITS_DEF = 10;
  localparam int SCREEN_WIDTH      = 128;
  localparam int SCREEN_HEIGHT     = 64;
  localparam int STEP_SIZE         = 2;

  localparam int COORD_W   = 11;
  localparam int PIXEL_X_W = 7;
  localparam int PIXEL_Y_W = 6;
  localparam int PT_W      = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y     = 3'd5;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

endpackage

FILE: rtl/core/quadratic_bezier_point_generator_unit.sv
// Top level of the quadratic Bezier point generator.
// Depends on qbez_pkg and qbez_mac.
//
// Usage:
//   Control points p0/p1/p2 are written through cfg_we/cfg_index/cfg_data
//   (index 0..5: start_x, start_y, control_x, control_y, end_x, end_y); the
//   user must write them only while the block is idle; the block does not
//   enforce this. Writes to other indexes are dropped. Each input beat
//   (restart) produces one output beat (pixel_x, pixel_y, visible, last) for
//   the curve at t/2^FRACTION_BITS; t then steps by 2, wrapping to 0 after
//   the last sample. restart=1 evaluates at t=0. One shared multiplier runs
//   nine multiply steps (three weights, three terms per axis), then a finish
//   state scales, clips and loads the output register and the sequencer
//   returns to idle; a new beat is not taken until the last one has been
//   evaluated and loaded into the output register.
//   in_ready is high only while the sequencer is idle. A finished result
//   that the receiver stalls waits in the sequencer until the output
//   register frees; the held output beat does not block a new input beat.
//   Reset (rst, synchronous) clears t, the control points and out_valid.
module quadratic_bezier_point_generator_unit import qbez_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_X_W-1:0]  pixel_x,
  output logic [PIXEL_Y_W-1:0]  pixel_y,
  output logic                  visible,
  output logic                  last
);

  localparam int T_W   = FRACTION_BITS + 1;
  localparam int WGT_W = 2 * FRACTION_BITS + 1;
  localparam int B_W   = (FRACTION_BITS + 2 > COORD_W) ? FRACTION_BITS + 2 : COORD_W;
  localparam int ACC_W = 2 * FRACTION_BITS + 12;
  localparam int SHIFT = 2 * FRACTION_BITS;
  localparam logic [T_W-1:0]   SCALE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] BIAS  = {{(ACC_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_UU  = 4'd0;
  localparam logic [STEP_W-1:0] ST_UT  = 4'd1;
  localparam logic [STEP_W-1:0] ST_TT  = 4'd2;
  localparam logic [STEP_W-1:0] ST_X0  = 4'd3;
  localparam logic [STEP_W-1:0] ST_X1  = 4'd4;
  localparam logic [STEP_W-1:0] ST_X2  = 4'd5;
  localparam logic [STEP_W-1:0] ST_Y0  = 4'd6;
  localparam logic [STEP_W-1:0] ST_Y1  = 4'd7;
  localparam logic [STEP_W-1:0] ST_Y2  = 4'd8;

  logic [1:0]              state;
  logic [STEP_W-1:0]       step;
  logic [T_W-1:0]          curve_param;
  logic [T_W-1:0]          t_cur;
  logic [T_W-1:0]          u_cur;
  logic [WGT_W-1:0]        uu;
  logic [WGT_W-1:0]        ut2;
  logic [WGT_W-1:0]        tt;
  logic signed [PT_W-1:0]  x_pt;
  logic signed [PT_W-1:0]  y_pt;
  logic                    vis;

  logic signed [COORD_W-1:0] start_x, start_y, control_x, control_y, end_x, end_y;

  mac_ctl_t                  mac_ctl;
  logic [WGT_W-1:0]          op_a;
  logic signed [B_W-1:0]     op_b;
  logic signed [WGT_W+B_W:0] prod;
  logic signed [ACC_W-1:0]   acc;

  function automatic logic signed [PT_W-1:0] scale_down(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] b;
    b = s + (s[ACC_W-1] ? $signed(BIAS) : $signed({ACC_W{1'b0}}));
    return PT_W'(b >>> SHIFT);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign u_cur    = SCALE - t_cur;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      ST_UU: begin
        op_a = WGT_W'(u_cur);
        op_b = $signed(B_W'(u_cur));
      end
      ST_UT: begin
        op_a = WGT_W'(u_cur);
        op_b = $signed(B_W'(t_cur));
      end
      ST_TT: begin
        op_a = WGT_W'(t_cur);
        op_b = $signed(B_W'(t_cur));
      end
      ST_X0: begin
        op_a = uu;
        op_b = B_W'(start_x);
      end
      ST_X1: begin
        op_a = ut2;
        op_b = B_W'(control_x);
      end
      ST_X2: begin
        op_a = tt;
        op_b = B_W'(end_x);
      end
      ST_Y0: begin
        op_a = uu;
        op_b = B_W'(start_y);
      end
      ST_Y1: begin
        op_a = ut2;
        op_b = B_W'(control_y);
      end
      ST_Y2: begin
        op_a = tt;
        op_b = B_W'(end_y);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mac_ctl.en  = (state == S_CALC) && (step >= ST_X0);
  assign mac_ctl.clr = (step == ST_X0) || (step == ST_Y0);

  qbez_mac #(
    .A_W   (WGT_W),
    .B_W   (B_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  assign y_pt = scale_down(acc);
  assign vis  = !x_pt[PT_W-1] && (x_pt < $signed(PT_W'(SCREEN_WIDTH))) &&
                !y_pt[PT_W-1] && (y_pt < $signed(PT_W'(SCREEN_HEIGHT)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      curve_param <= '0;
      start_x     <= '0;
      start_y     <= '0;
      control_x   <= '0;
      control_y   <= '0;
      end_x       <= '0;
      end_y       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X:   start_x   <= cfg_data;
          REG_START_Y:   start_y   <= cfg_data;
          REG_CONTROL_X: control_x <= cfg_data;
          REG_CONTROL_Y: control_y <= cfg_data;
          REG_END_X:     end_x     <= cfg_data;
          REG_END_Y:     end_y     <= cfg_data;
          default: ;
        endcase
      end
      if (out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t_cur <= restart ? '0 : curve_param;
            step  <= ST_UU;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          case (step)
            ST_UU:   uu   <= prod[WGT_W-1:0];
            ST_UT:   ut2  <= {prod[WGT_W-2:0], 1'b0};
            ST_TT:   tt   <= prod[WGT_W-1:0];
            ST_Y0:   x_pt <= scale_down(acc);
            default: ;
          endcase
          step <= step + 1'b1;
          if (step == ST_Y2) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            pixel_x     <= vis ? x_pt[PIXEL_X_W-1:0] : '0;
            pixel_y     <= vis ? y_pt[PIXEL_Y_W-1:0] : '0;
            visible     <= vis;
            last        <= t_cur[FRACTION_BITS];
            curve_param <= t_cur[FRACTION_BITS] ? '0 : t_cur + T_W'(STEP_SIZE);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/qbez_mac.sv
// Shared multiply-accumulate unit: one signed multiplier and an accumulator.
// Depends on qbez_pkg (mac_ctl_t).
module qbez_mac import qbez_pkg::*; #(
  parameter int A_W   = 2 * FRACTION_BITS_DEF + 1,
  parameter int B_W   = COORD_W,
  parameter int ACC_W = 2 * FRACTION_BITS_DEF + 12
) (
  input  logic                          clk,
  input  mac_ctl_t                      ctl,
  input  logic        [A_W-1:0]         op_a,
  input  logic signed [B_W-1:0]         op_b,
  output logic signed [A_W+B_W:0]       prod,
  output logic signed [ACC_W-1:0]       acc
);

  assign prod = $signed({1'b0, op_a}) * op_b;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.clr ? '0 : acc) + $signed(prod[ACC_W-1:0]);
    end
  end

endmodule

FILE: rtl/core/qbez_checker.sv
// Port-level checker for the quadratic Bezier point generator, bound to the top.
// Depends on qbez_pkg and quadratic_bezier_point_generator_unit_macros.svh.
`include "quadratic_bezier_point_generator_unit_macros.svh"

module qbez_checker import qbez_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIXEL_X_W-1:0] pixel_x,
  input logic [PIXEL_Y_W-1:0] pixel_y,
  input logic                 visible,
  input logic                 last
);

  `QBEZ_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(visible) && $stable(last), "output beat changed while stalled")
  `QBEZ_CHECK(a_hidden_zero, out_valid && !visible |-> pixel_x == '0 && pixel_y == '0, "hidden point has nonzero coordinates")
  `QBEZ_CHECK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input accepted while evaluating")
  `QBEZ_CHECK_RST(a_reset_idle, rst |=> !out_valid && in_ready, "block not idle after reset")

endmodule

bind quadratic_bezier_point_generator_unit qbez_checker u_qbez_checker (.*);

FILE: tb/bezier_tb_pkg.sv
// Point tracker for the quadratic Bezier point generator testbench: keeps the
// control points and curve position, predicts each point and checks the results.
// Depends on qbez_pkg.
package bezier_tb_pkg;
  import qbez_pkg::*;

  localparam int PARAM_W = FRACTION_BITS_DEF + 1;
  localparam longint CURVE_SCALE = longint'(1) << FRACTION_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [PIXEL_X_W-1:0] px;
    logic [PIXEL_Y_W-1:0] py;
    logic                 vis;
    logic                 fin;
  } point_t;

  class point_tracker;
    logic signed [COORD_W-1:0] ctrl [6];
    logic [PARAM_W-1:0]        t_now;
    point_t                    expected_points [$];
    int                        mismatches;
    int                        wraps;

    function new();
      foreach (ctrl[i]) ctrl[i] = '0;
      t_now      = '0;
      mismatches = 0;
      wraps      = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx <= REG_END_Y) ctrl[idx] = val;
    endfunction

    function longint blend(longint tt, longint a, longint b, longint c);
      longint uu;
      uu = CURVE_SCALE - tt;
      return (uu * uu * a + 2 * uu * tt * b + tt * tt * c) / (CURVE_SCALE * CURVE_SCALE);
    endfunction

    function void note_step(bit rs);
      longint x;
      longint y;
      point_t p;
      if (rs) t_now = '0;
      x = blend(t_now, ctrl[REG_START_X], ctrl[REG_CONTROL_X], ctrl[REG_END_X]);
      y = blend(t_now, ctrl[REG_START_Y], ctrl[REG_CONTROL_Y], ctrl[REG_END_Y]);
      p.vis = (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_HEIGHT);
      p.px  = p.vis ? x[PIXEL_X_W-1:0] : '0;
      p.py  = p.vis ? y[PIXEL_Y_W-1:0] : '0;
      p.fin = (longint'(t_now) >= CURVE_SCALE);
      expected_points.push_back(p);
      if (p.fin) begin
        wraps++;
        t_now = '0;
      end else begin
        t_now = t_now + PARAM_W'(STEP_SIZE);
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_point(logic [PIXEL_X_W-1:0] px, logic [PIXEL_Y_W-1:0] py,
                     logic vis, logic fin);
      point_t want;
      if (expected_points.size() == 0) begin
        report_mismatch("output beat with no point expected");
        return;
      end
      want = expected_points.pop_front();
      if (px !== want.px)
        report_mismatch($sformatf("pixel_x got %0d want %0d", px, want.px));
      if (py !== want.py)
        report_mismatch($sformatf("pixel_y got %0d want %0d", py, want.py));
      if (vis !== want.vis)
        report_mismatch($sformatf("visible got %0b want %0b", vis, want.vis));
      if (fin !== want.fin)
        report_mismatch($sformatf("last got %0b want %0b", fin, want.fin));
    endtask
  endclass

endpackage

FILE: tb/testbench.sv
// Top-level testbench for quadratic_bezier_point_generator_unit: directed curves,
// then random control points with random idling on both sides and a long output hold.
// Depends on qbez_pkg and bezier_tb_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qbez_pkg::*;
  import bezier_tb_pkg::*;

  localparam logic [COORD_W-1:0] COORD_MIN  = 11'h400;
  localparam logic [COORD_W-1:0] COORD_MAX  = 11'h3FF;
  localparam logic [COORD_W-1:0] COORD_NEG1 = 11'h7FF;
  localparam logic [5:0][CFG_IDX_W-1:0] CURVE_REGS = {REG_END_Y, REG_END_X, REG_CONTROL_Y,
                                                      REG_CONTROL_X, REG_START_Y, REG_START_X};
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 72;
  localparam int RESTART_ODDS  = 40;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 restart   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIXEL_X_W-1:0] pixel_x;
  logic [PIXEL_Y_W-1:0] pixel_y;
  logic                 visible;
  logic                 last;

  point_tracker sb = new();
  bit fast_mode = 1'b0;
  bit hold_req  = 1'b0;
  int stall_left = 0;
  int sink_roll;
  int cycle_count = 0;

  quadratic_bezier_point_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL quadratic_bezier_point_generator_unit");
      $finish;
    end
  end

  // output side: check each beat, then pick next ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_point(pixel_x, pixel_y, visible, last);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (fast_mode) begin
        out_ready <= 1'b1;
      end else begin
        sink_roll = $urandom_range(0, 99);
        if (sink_roll < 70) begin
          out_ready <= 1'b1;
        end else begin
          stall_left = (sink_roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          out_ready <= 1'b0;
        end
      end
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord(bit is_y);
    int roll;
    int lim;
    roll = $urandom_range(0, 9);
    lim  = is_y ? SCREEN_HEIGHT : SCREEN_WIDTH;
    if (roll == 0) return COORD_MIN;
    if (roll == 1) return COORD_MAX;
    if (roll < 4) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, lim + 8) - 4);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.load_reg(idx, val);
  endtask

  task automatic program_curve(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                               input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                               input logic [5:0] mask, input bit poke_spare);
    logic [5:0][COORD_W-1:0] vals;
    vals = {ey, ex, cy, cx, sy, sx};
    for (int i = 0; i < 6; i++) begin
      if (mask[i]) write_reg(CURVE_REGS[i], vals[i]);
    end
    if (poke_spare) begin
      write_reg(REG_SPARE_LO, COORD_NEG1);
      write_reg(REG_SPARE_HI, COORD_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // Sends count steps, then waits until every point is back and the block is idle.
  task automatic play_segment(input int count, input bit lead_restart,
                              input int restart_odds, input bit early);
    bit rs;
    int gap;
    int roll;
    for (int n = 0; n < count; n++) begin
      if (n == 0)
        rs = lead_restart;
      else
        rs = (restart_odds > 0) && (early || sb.wraps > 0) &&
             ($urandom_range(1, restart_odds) == 1);
      roll = $urandom_range(0, 99);
      if (fast_mode || roll < 60)
        gap = 0;
      else if (roll < 92)
        gap = $urandom_range(1, 3);
      else
        gap = $urandom_range(8, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      restart  <= rs;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_step(rs);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    play_segment(3, 1'b1, 0, 1'b0);
    program_curve(11'd127, 11'd63, 11'd127, 11'd63, 11'd127, 11'd63, 6'h3F, 1'b0);
    play_segment(2, 1'b1, 0, 1'b0);
    program_curve(11'd128, 11'd0, 11'd128, 11'd0, 11'd128, 11'd0, 6'h3F, 1'b0);
    play_segment(2, 1'b0, 0, 1'b0);
    program_curve(COORD_NEG1, 11'd10, COORD_NEG1, 11'd10, COORD_NEG1, 11'd10, 6'h3F, 1'b0);
    play_segment(2, 1'b0, 0, 1'b0);
    program_curve(11'd5, 11'd64, 11'd5, 11'd64, 11'd5, 11'd64, 6'h3F, 1'b0);
    play_segment(2, 1'b1, 0, 1'b0);
    program_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                  6'h3F, 1'b0);
    play_segment(3, 1'b1, 0, 1'b0);
    // small negative sums must truncate to zero, not round down off screen
    program_curve(11'd0, 11'd0, 11'd0, 11'd0, COORD_NEG1, COORD_NEG1, 6'h3F, 1'b1);
    play_segment(3, 1'b1, 0, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_curve(pick_coord(1'b0), pick_coord(1'b1), pick_coord(1'b0),
                    pick_coord(1'b1), pick_coord(1'b0), pick_coord(1'b1),
                    (phase == 0) ? 6'h3F : 6'($urandom_range(1, 63)),
                    $urandom_range(0, 2) == 0);
      fast_mode = (phase == 3);
      if (phase == 2) hold_req = 1'b1;
      play_segment(PHASE_ITEMS,
                   (phase == 0 || sb.wraps > 0) && ($urandom_range(1, RESTART_ODDS) == 1),
                   RESTART_ODDS, phase == 0);
    end
    fast_mode = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS quadratic_bezier_point_generator_unit");
    else
      $display("FAIL quadratic_bezier_point_generator_unit");
    $finish;
  end

endmodule

FILE: quadratic_bezier_point_generator_unit.f
+incdir+rtl/core
rtl/core/qbez_pkg.sv
rtl/core/qbez_mac.sv
rtl/core/quadratic_bezier_point_generator_unit.sv
rtl/core/qbez_checker.sv
tb/bezier_tb_pkg.sv
tb/testbench.sv
